>>> rtl/core/bounded_list_store_assert.svh
// ============================================================================
// Assertion macros for the bounded list store
// Clocked on clk and disabled while rst_n is low.
// ============================================================================
`ifndef BOUNDED_LIST_STORE_ASSERT_SVH
`define BOUNDED_LIST_STORE_ASSERT_SVH

// Check a condition in the same cycle as its trigger
`define BLS_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define BLS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/core/bls_pkg.sv
// ============================================================================
// bls_pkg
// Shared types, request codes and status codes of the bounded list store.
// ============================================================================
package bls_pkg;

    localparam int unsigned DEF_CAPACITY    = 64;
    localparam int unsigned DEF_VALUE_WIDTH = 32;

    typedef logic [2:0] cmd_t;
    typedef logic [1:0] status_t;

    localparam cmd_t CMD_SEARCH    = 3'd0;
    localparam cmd_t CMD_INS_FRONT = 3'd1;
    localparam cmd_t CMD_INS_BACK  = 3'd2;
    localparam cmd_t CMD_DEL_FRONT = 3'd3;
    localparam cmd_t CMD_DEL_BACK  = 3'd4;
    localparam cmd_t CMD_DEL_MATCH = 3'd5;
    localparam cmd_t CMD_SORT      = 3'd6;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_EMPTY     = 2'd1;
    localparam status_t ST_NOT_FOUND = 2'd2;
    localparam status_t ST_FULL      = 2'd3;

endpackage

>>> rtl/core/bounded_list_store.sv
// ============================================================================
// bounded_list_store
// Ordered list of up to CAPACITY signed values kept front to back in one
// entry memory. Requests search, insert, delete or sort the list; each
// request returns one status and the new count.
// ============================================================================
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-------------------------
//  request   | start / busy          | cmd, value
//  result    | done (one-cycle)      | status, count
//
//  Insert back, delete back, full, empty and unused codes finish without
//  walking the memory. Search walks the list front to back. Delete match
//  scans and shifts the tail down in the same walk. Through the single read
//  port, insert front and delete front shift the list entry by entry.
//  Sort is a bubble sort with early exit.
//  No clearing pass after reset; the count starts at zero. Results cannot be
//  stalled; busy stays high only while a request walks the memory.
// ============================================================================
module bounded_list_store #(
    parameter int unsigned CAPACITY    = bls_pkg::DEF_CAPACITY,
    parameter int unsigned VALUE_WIDTH = bls_pkg::DEF_VALUE_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  bls_pkg::cmd_t       cmd,
    input  logic signed [31:0]  value,
    output logic                done,
    output bls_pkg::status_t    status,
    output logic [6:0]          count
);

    import bls_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_SHDN = 3'd2;
    localparam logic [2:0] S_SHUP = 3'd3;
    localparam logic [2:0] S_SORT = 3'd4;

    logic [2:0]                    state_reg,  state_next;
    logic [CW-1:0]                 cnt_reg,    cnt_next;
    logic [CW-1:0]                 idx_reg,    idx_next;
    logic [CW-1:0]                 lim_reg,    lim_next;
    logic                          pend_reg,   pend_next;
    logic                          swap_reg,   swap_next;
    logic                          done_reg,   done_next;
    status_t                       status_reg, status_next;
    cmd_t                          cmd_reg,    cmd_next;
    logic [VALUE_WIDTH-1:0]        val_reg,    val_next;
    logic signed [VALUE_WIDTH-1:0] carry_reg,  carry_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;

    logic signed [63:0]     value_ext;
    logic [VALUE_WIDTH-1:0] v_in;
    logic [CW-1:0]          idx_m1;
    logic [CW-1:0]          idx_m2;
    logic [CW-1:0]          idx_p1;
    logic                   issue;
    logic                   hit;

    // Sign-extend the request value, then cut it to the stored width
    assign value_ext = 64'(value);
    assign v_in      = value_ext[VALUE_WIDTH-1:0];

    assign idx_m1 = idx_reg - CW'(1);
    assign idx_m2 = idx_reg - CW'(2);
    assign idx_p1 = idx_reg + CW'(1);
    assign hit    = pend_reg && (ram_rdata == val_reg);

    bls_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequence each request through read, modify and write back
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        lim_next    = lim_reg;
        pend_next   = pend_reg;
        swap_next   = swap_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        cmd_next    = cmd_reg;
        val_next    = val_reg;
        carry_next  = carry_reg;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = val_reg;
        ram_raddr   = idx_reg[AW-1:0];
        issue       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    val_next  = v_in;
                    cmd_next  = cmd;
                    pend_next = 1'b0;
                    swap_next = 1'b0;
                    unique case (cmd)
                        CMD_SEARCH, CMD_DEL_MATCH:
                        begin
                            if (cnt_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        CMD_INS_FRONT:
                        begin
                            if (cnt_reg == CAP_C)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                idx_next   = cnt_reg;
                                state_next = S_SHUP;
                            end
                        end
                        CMD_INS_BACK:
                        begin
                            done_next = 1'b1;
                            if (cnt_reg == CAP_C)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we      = 1'b1;
                                ram_waddr   = cnt_reg[AW-1:0];
                                ram_wdata   = v_in;
                                cnt_next    = cnt_reg + CW'(1);
                                status_next = ST_OK;
                            end
                        end
                        CMD_DEL_FRONT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                idx_next   = CW'(1);
                                state_next = S_SHDN;
                            end
                        end
                        CMD_DEL_BACK:
                        begin
                            done_next = 1'b1;
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                cnt_next    = cnt_reg - CW'(1);
                                status_next = ST_OK;
                            end
                        end
                        CMD_SORT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else if (cnt_reg == CW'(1))
                            begin
                                done_next   = 1'b1;
                                status_next = ST_OK;
                            end
                            else
                            begin
                                idx_next   = '0;
                                lim_next   = cnt_reg - CW'(1);
                                state_next = S_SORT;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            // Walk front to back looking for the first equal entry
            S_SCAN:
            begin
                issue     = idx_reg < cnt_reg;
                pend_next = issue;
                if (issue)
                begin
                    idx_next = idx_p1;
                end
                if (hit)
                begin
                    if (cmd_reg == CMD_SEARCH)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SHDN;
                    end
                end
                else if (idx_reg == cnt_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_NOT_FOUND;
                    state_next  = S_IDLE;
                end
            end

            // Move the tail down by one entry over the removed one
            S_SHDN:
            begin
                issue     = idx_reg < cnt_reg;
                pend_next = issue;
                if (issue)
                begin
                    idx_next = idx_p1;
                end
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_m2[AW-1:0];
                    ram_wdata = ram_rdata;
                end
                if (idx_reg == cnt_reg)
                begin
                    cnt_next    = cnt_reg - CW'(1);
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_IDLE;
                end
            end

            // Move the list up by one entry, back to front, then place the head
            S_SHUP:
            begin
                ram_raddr = idx_m1[AW-1:0];
                issue     = idx_reg != '0;
                pend_next = issue;
                if (issue)
                begin
                    idx_next = idx_m1;
                end
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_p1[AW-1:0];
                    ram_wdata = ram_rdata;
                end
                else if (!issue)
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = '0;
                    ram_wdata   = val_reg;
                    cnt_next    = cnt_reg + CW'(1);
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    state_next  = S_IDLE;
                end
            end

            // Bubble the largest entry of each pass up to the pass limit
            S_SORT:
            begin
                issue     = idx_reg <= lim_reg;
                pend_next = issue;
                if (issue)
                begin
                    idx_next = idx_p1;
                end
                if (pend_reg)
                begin
                    if (idx_m1 == '0)
                    begin
                        carry_next = $signed(ram_rdata);
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = idx_m2[AW-1:0];
                        if (carry_reg > $signed(ram_rdata))
                        begin
                            ram_wdata = ram_rdata;
                            swap_next = 1'b1;
                        end
                        else
                        begin
                            ram_wdata  = carry_reg;
                            carry_next = $signed(ram_rdata);
                        end
                    end
                end
                else if (!issue)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = lim_reg[AW-1:0];
                    ram_wdata = carry_reg;
                    if (!swap_reg || lim_reg == CW'(1))
                    begin
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        lim_next  = lim_reg - CW'(1);
                        idx_next  = '0;
                        swap_next = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            lim_reg    <= '0;
            pend_reg   <= 1'b0;
            swap_reg   <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            cmd_reg    <= CMD_SEARCH;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            lim_reg    <= lim_next;
            pend_reg   <= pend_next;
            swap_reg   <= swap_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            cmd_reg    <= cmd_next;
        end
    end

    // Hold request operand and sort carry
    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        carry_reg <= carry_next;
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign status = status_reg;
    assign count  = 7'(cnt_reg);

    // Flag full and empty results for the checks below
    logic done_full;
    logic done_empty;

    assign done_full  = done_reg && (status_reg == ST_FULL);
    assign done_empty = done_reg && (status_reg == ST_EMPTY);

`include "bounded_list_store_assert.svh"

    `BLS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CAP_C, "count above capacity")
    `BLS_ASSERT_NOW(a_done_idle, done_reg, state_reg == S_IDLE, "result while still walking")
    `BLS_ASSERT_NOW(a_full_count, done_full, cnt_reg == CAP_C, "full status below capacity")
    `BLS_ASSERT_NOW(a_empty_count, done_empty, cnt_reg == '0, "empty status with entries")
    `BLS_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done_reg, "request not taken up")

endmodule

>>> rtl/core/bls_ram.sv
// ============================================================================
// bls_ram
// Simple dual-port entry store: one write port, one read port, read data
// registered (old data on a same-address collision).
// ============================================================================
module bls_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry and read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> tb/tb_bounded_list_store.sv
// ============================================================================
// tb_bounded_list_store
// Self-checking bench for the bounded list store. A queue of requests feeds a
// start/busy driver: a short directed run over the empty and single-entry
// corners, then random fill, mixed and drain phases. A shadow list
// predicts status and count for every accepted request, and the monitor
// checks each done strobe against the oldest prediction.
// ============================================================================
module tb_bounded_list_store;
    import bls_pkg::*;

    localparam int   LIST_DEPTH      = DEF_CAPACITY;
    localparam cmd_t CMD_UNUSED      = 3'd7;
    localparam int   RANDOM_REQUESTS = 600;
    localparam int   CYCLE_LIMIT     = 10_000_000;
    localparam int   DRAIN_CYCLES    = 200;
    localparam int   POOL_SIZE       = 10;

    typedef struct {
        cmd_t               cmd;
        logic signed [31:0] value;
    } list_request_t;

    typedef struct {
        cmd_t               cmd;
        logic signed [31:0] value;
        status_t            status;
        logic [6:0]         count;
    } list_outcome_t;

    typedef enum {PH_FILL, PH_MIXED, PH_DRAIN} stim_phase_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_start = 1'b0;
    logic               busy;
    cmd_t               req_cmd = CMD_SEARCH;
    logic signed [31:0] req_value = '0;
    logic               done;
    status_t            status;
    logic [6:0]         count;

    list_request_t      pending_requests[$];
    list_outcome_t      expected_results[$];

    logic signed [31:0] shadow_list [LIST_DEPTH];
    int                 shadow_len = 0;
    logic signed [31:0] value_pool [POOL_SIZE];

    int                 mismatch_count = 0;
    int                 cycle_count = 0;
    int                 gap_left = 0;
    int                 quiet_left = 0;

    bounded_list_store dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (req_start),
        .busy   (busy),
        .cmd    (req_cmd),
        .value  (req_value),
        .done   (done),
        .status (status),
        .count  (count)
    );

    // Clock and a single reset pulse
    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string field, input int want, input int got,
                                   input cmd_t op);
        $display("mismatch: %s after cmd %0d, expected %0d, got %0d", field, op, want, got);
        mismatch_count++;
    endtask

    // Apply one request to the shadow list and queue the status and count it yields
    task automatic apply_list_request(input cmd_t op, input logic signed [31:0] operand);
        list_outcome_t      outcome;
        int                 hit;
        int                 drop_at;
        int                 i;
        int                 j;
        logic signed [31:0] held;
        hit = -1;
        drop_at = -1;
        for (i = 0; i < shadow_len; i++)
            if (hit < 0 && shadow_list[i] == operand)
                hit = i;
        outcome.status = ST_OK;
        case (op)
            CMD_SEARCH:
                if (shadow_len == 0)
                    outcome.status = ST_EMPTY;
                else if (hit < 0)
                    outcome.status = ST_NOT_FOUND;
            CMD_INS_FRONT, CMD_INS_BACK:
                if (shadow_len >= LIST_DEPTH)
                    outcome.status = ST_FULL;
                else if (op == CMD_INS_FRONT || shadow_len == 0)
                begin
                    for (i = shadow_len; i > 0; i--)
                        shadow_list[i] = shadow_list[i - 1];
                    shadow_list[0] = operand;
                    shadow_len++;
                end
                else
                begin
                    shadow_list[shadow_len] = operand;
                    shadow_len++;
                end
            CMD_DEL_FRONT:
                if (shadow_len == 0)
                    outcome.status = ST_EMPTY;
                else
                    drop_at = 0;
            CMD_DEL_BACK:
                if (shadow_len == 0)
                    outcome.status = ST_EMPTY;
                else
                    shadow_len--;
            CMD_DEL_MATCH:
                if (shadow_len == 0)
                    outcome.status = ST_EMPTY;
                else if (hit < 0)
                    outcome.status = ST_NOT_FOUND;
                else
                    drop_at = hit;
            CMD_SORT:
                if (shadow_len == 0)
                    outcome.status = ST_EMPTY;
                else
                begin
                    for (i = 1; i < shadow_len; i++)
                    begin
                        held = shadow_list[i];
                        j = i;
                        while (j > 0 && shadow_list[j - 1] > held)
                        begin
                            shadow_list[j] = shadow_list[j - 1];
                            j--;
                        end
                        shadow_list[j] = held;
                    end
                end
            default: ;
        endcase
        // Close the gap left by a removed entry
        if (drop_at >= 0)
        begin
            for (i = drop_at; i + 1 < shadow_len; i++)
                shadow_list[i] = shadow_list[i + 1];
            shadow_len--;
        end
        outcome.cmd   = op;
        outcome.value = operand;
        outcome.count = 7'(shadow_len);
        expected_results.push_back(outcome);
    endtask

    function automatic void queue_request(input cmd_t op, input logic signed [31:0] operand);
        list_request_t rq;
        rq.cmd   = op;
        rq.value = operand;
        pending_requests.push_back(rq);
    endfunction

    // Favor pool values so searches and deletes often hit stored entries
    function automatic logic signed [31:0] pick_operand();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 70)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        return $signed($urandom());
    endfunction

    function automatic list_request_t make_request(input stim_phase_t phase);
        list_request_t rq;
        int            r;
        rq.value = pick_operand();
        rq.cmd   = cmd_t'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        if (phase == PH_FILL && r < 95)
            rq.cmd = ($urandom_range(0, 1) != 0) ? CMD_INS_FRONT : CMD_INS_BACK;
        else if (phase == PH_DRAIN && r < 85)
        begin
            case ($urandom_range(0, 2))
                0: rq.cmd = CMD_DEL_FRONT;
                1: rq.cmd = CMD_DEL_BACK;
                default: rq.cmd = CMD_DEL_MATCH;
            endcase
        end
        return rq;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones, and back-to-back bursts
    function automatic int pick_gap();
        int r;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
            quiet_left = $urandom_range(20, 40);
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Driver: hold the request until accepted, then advance or idle
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        list_request_t nxt;
        int            gap;
        if (!rst_n)
        begin
            req_start <= 1'b0;
            req_cmd   <= CMD_SEARCH;
            req_value <= '0;
            gap_left  <= 0;
        end
        else if (req_start && !busy)
        begin
            apply_list_request(req_cmd, req_value);
            gap = pick_gap();
            if (gap == 0 && pending_requests.size() != 0)
            begin
                nxt = pending_requests.pop_front();
                req_cmd   <= nxt.cmd;
                req_value <= nxt.value;
            end
            else
            begin
                req_start <= 1'b0;
                gap_left  <= (gap > 0) ? gap - 1 : 0;
            end
        end
        else if (!req_start)
        begin
            if (gap_left > 0)
                gap_left <= gap_left - 1;
            else if (pending_requests.size() != 0)
            begin
                nxt = pending_requests.pop_front();
                req_start <= 1'b1;
                req_cmd   <= nxt.cmd;
                req_value <= nxt.value;
            end
        end
    end

    // Monitor: check each done strobe against the oldest prediction
    always @(posedge clk)
    begin : result_monitor
        list_outcome_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with no request outstanding", -1, int'(status),
                                CMD_UNUSED);
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", int'(want.status), int'(status), want.cmd);
                if (count !== want.count)
                    report_mismatch("count", int'(want.count), int'(count), want.cmd);
            end
        end
    end

    // Give up on a hang
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int          made;
        int          block_len;
        int          k;
        int          phase_no;
        stim_phase_t phase;
        made = 0;
        phase_no = 0;
        for (k = 0; k < POOL_SIZE; k++)
            value_pool[k] = (k < 4) ? 32'(k - 2) : $signed($urandom());

        // Empty list corners, including the unused code
        queue_request(CMD_SEARCH, 32'sd5);
        queue_request(CMD_DEL_MATCH, 32'sd5);
        queue_request(CMD_DEL_FRONT, 32'sd0);
        queue_request(CMD_DEL_BACK, 32'sd0);
        queue_request(CMD_SORT, 32'sd0);
        queue_request(CMD_UNUSED, $signed($urandom()));
        // Insert back on empty acts as insert front; delete back of one entry
        queue_request(CMD_INS_BACK, 32'sh7FFF_FFFF);
        queue_request(CMD_DEL_BACK, 32'sd0);
        queue_request(CMD_INS_BACK, 32'sh8000_0000);
        queue_request(CMD_INS_FRONT, 32'sh7FFF_FFFF);
        queue_request(CMD_INS_BACK, -32'sd1);
        queue_request(CMD_INS_FRONT, 32'sd0);
        queue_request(CMD_SEARCH, 32'sh8000_0000);
        queue_request(CMD_SEARCH, 32'sd12345);
        // Delete match on the head entry
        queue_request(CMD_DEL_MATCH, 32'sd0);
        queue_request(CMD_SORT, 32'sd0);
        queue_request(CMD_SEARCH, -32'sd1);
        queue_request(CMD_DEL_MATCH, 32'sh7FFF_FFFF);
        queue_request(CMD_DEL_FRONT, 32'sd0);
        queue_request(CMD_INS_FRONT, 32'sh5555_5555);
        queue_request(CMD_INS_BACK, 32'shAAAA_AAAA);
        queue_request(CMD_DEL_MATCH, 32'sd42);
        queue_request(CMD_SORT, 32'sd0);
        queue_request(CMD_UNUSED, 32'sd0);

        // Random phases: fill to full, churn, then drain to empty
        while (made < RANDOM_REQUESTS)
        begin
            case (phase_no % 3)
                0: phase = PH_FILL;
                1: phase = PH_MIXED;
                default: phase = PH_DRAIN;
            endcase
            block_len = (phase == PH_MIXED) ? 60 : 90;
            for (k = 0; k < block_len; k++)
                pending_requests.push_back(make_request(phase));
            made += block_len;
            phase_no++;
        end

        @(posedge rst_n);
        while (pending_requests.size() != 0 || req_start || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
